>>> design/psch_pkg.sv
// shared types and constants for the preemptive priority scheduler
package psch_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CFG_W  = 5;
  localparam int PRIO_W = 8;
  localparam int TIME_W = 16;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        slot;
    logic [PRIO_W-1:0] prio_value;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
  } req_t;

  typedef struct packed {
    logic              ran;
    logic [3:0]        ran_slot;
    logic              finished;
    logic [TIME_W-1:0] fin_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } rsp_t;

  // one process table entry
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [TIME_W-1:0] remaining;
  } entry_t;

  // write side of the process table
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

>>> design/psch_mem.sv
// process table memory, one write port and one registered read port
module psch_mem (
  input  logic                        clk,
  input  psch_pkg::mem_wr_t           wr,
  input  logic [psch_pkg::SLOT_W-1:0] rd_addr,
  output psch_pkg::entry_t            rd_data
);

  psch_pkg::entry_t mem [psch_pkg::SLOTS];

  // write and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> design/psch_alu.sv
// shared compare and saturating subtract unit
module psch_alu (
  input  logic [psch_pkg::TIME_W-1:0] a,
  input  logic [psch_pkg::TIME_W-1:0] b,
  output logic                        lt,
  output logic [psch_pkg::TIME_W-1:0] diff
);

  // a - b, floored at zero
  always_comb begin
    lt   = (a < b);
    diff = lt ? '0 : a - b;
  end

endmodule

>>> design/preemptive_priority_scheduler.sv
// preemptive priority scheduler top level: sequencer, process table and shared unit
// a load beat passes through the load state to the emit state, where its result is registered
// a tick beat scans the slots in use one per cycle through the table read port,
//   then updates the served entry, and works out turnaround and waiting when it finishes
// one beat is in work at a time; the next one is taken once the result is registered
// synchronous reset clears time, done flags, process count and the sequencer
module preemptive_priority_scheduler (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_ready,
  input  psch_pkg::req_t             req,
  output logic                       rsp_valid,
  input  logic                       rsp_ready,
  output psch_pkg::rsp_t             rsp,
  input  logic                       cfg_we,
  input  logic [psch_pkg::CFG_W-1:0] cfg_wdata
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_LOAD   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_UPDATE = 7'b0001000,
    ST_TAT    = 7'b0010000,
    ST_WAIT   = 7'b0100000,
    ST_EMIT   = 7'b1000000
  } state_t;

  state_t                         state;
  psch_pkg::req_t                 item;
  logic [psch_pkg::CFG_W-1:0]     count;
  logic [psch_pkg::TIME_W-1:0]    now_time;
  logic [psch_pkg::SLOTS-1:0]     done;
  logic [psch_pkg::CNT_W-1:0]     idx;
  logic                           rd_vld;
  logic [psch_pkg::SLOT_W-1:0]    rd_idx;
  logic                           best_vld;
  logic [psch_pkg::SLOT_W-1:0]    best_idx;
  psch_pkg::entry_t               best;
  logic                           ran;
  logic [psch_pkg::SLOT_W-1:0]    ran_slot;
  logic                           fin;
  logic [psch_pkg::TIME_W-1:0]    comp;
  logic [psch_pkg::TIME_W-1:0]    tat;
  logic [psch_pkg::TIME_W-1:0]    wait_time;

  logic [psch_pkg::CNT_W-1:0]     n_eff;
  logic                           all_done;
  logic [psch_pkg::TIME_W-1:0]    rem_next;
  logic [psch_pkg::TIME_W-1:0]    comp_next;
  logic                           take;
  logic                           slot_ok;
  logic                           emit_go;
  psch_pkg::mem_wr_t              mem_wr;
  psch_pkg::entry_t               rd_data;
  logic [psch_pkg::TIME_W-1:0]    alu_a;
  logic [psch_pkg::TIME_W-1:0]    alu_b;
  logic                           alu_lt;
  logic [psch_pkg::TIME_W-1:0]    alu_diff;

  assign req_ready = (state == ST_IDLE);

  // result register free to take the finished beat
  assign emit_go = (state == ST_EMIT) && (!rsp_valid || rsp_ready);

  // slots in use, capped at the table size
  always_comb begin
    if (count > psch_pkg::CFG_W'(psch_pkg::SLOTS)) begin
      n_eff = psch_pkg::CNT_W'(psch_pkg::SLOTS);
    end else begin
      n_eff = psch_pkg::CNT_W'(count);
    end
  end

  // every slot in use has finished
  always_comb begin
    all_done = 1'b1;
    for (int i = 0; i < psch_pkg::SLOTS; i++) begin
      if ((psch_pkg::CNT_W'(i) < n_eff) && !done[i]) begin
        all_done = 1'b0;
      end
    end
  end

  assign slot_ok = ({1'b0, item.slot} < (psch_pkg::SLOT_W + 1)'(psch_pkg::SLOTS));

  // served entry after one tick of service
  always_comb begin
    rem_next  = (best.remaining == '0) ? '0 : best.remaining - 1'b1;
    comp_next = (now_time == psch_pkg::TIME_MAX) ? psch_pkg::TIME_MAX : now_time + 1'b1;
  end

  // shared unit operand select
  always_comb begin
    unique case (state)
      ST_TAT: begin
        alu_a = comp;
        alu_b = best.arrival;
      end
      ST_WAIT: begin
        alu_a = tat;
        alu_b = best.burst;
      end
      default: begin
        alu_a = now_time;
        alu_b = rd_data.arrival;
      end
    endcase
  end

  psch_alu u_alu (
    .a    (alu_a),
    .b    (alu_b),
    .lt   (alu_lt),
    .diff (alu_diff)
  );

  // candidate from the table read beats the current best
  assign take = (state == ST_SCAN) && rd_vld && !done[rd_idx] && !alu_lt &&
                (!best_vld || (rd_data.prio < best.prio));

  // table write: load or remaining time update
  always_comb begin
    mem_wr = '0;
    if (state == ST_LOAD) begin
      mem_wr.en             = slot_ok;
      mem_wr.addr           = item.slot[psch_pkg::SLOT_W-1:0];
      mem_wr.data.prio      = item.prio_value;
      mem_wr.data.arrival   = item.arrival;
      mem_wr.data.burst     = item.burst;
      mem_wr.data.remaining = item.burst;
    end else if (state == ST_UPDATE) begin
      mem_wr.en             = best_vld;
      mem_wr.addr           = best_idx;
      mem_wr.data           = best;
      mem_wr.data.remaining = rem_next;
    end
  end

  psch_mem u_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .rd_addr (idx[psch_pkg::SLOT_W-1:0]),
    .rd_data (rd_data)
  );

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      now_time  <= '0;
      done      <= '0;
      idx       <= '0;
      rd_vld    <= 1'b0;
      best_vld  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        count <= cfg_wdata;
      end
      if (emit_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_valid) begin
            item      <= req;
            idx       <= '0;
            rd_vld    <= 1'b0;
            best_vld  <= 1'b0;
            ran       <= 1'b0;
            ran_slot  <= '0;
            fin       <= 1'b0;
            comp      <= '0;
            tat       <= '0;
            wait_time <= '0;
            state     <= (req.cmd == psch_pkg::CMD_LOAD) ? ST_LOAD : ST_SCAN;
          end
        end
        ST_LOAD: begin
          if (slot_ok) begin
            done[item.slot[psch_pkg::SLOT_W-1:0]] <= 1'b0;
          end
          state <= ST_EMIT;
        end
        ST_SCAN: begin
          // issue one read per cycle, judge it the cycle after
          if (take) begin
            best_vld <= 1'b1;
            best_idx <= rd_idx;
            best     <= rd_data;
          end
          if (idx < n_eff) begin
            rd_vld <= 1'b1;
            rd_idx <= idx[psch_pkg::SLOT_W-1:0];
            idx    <= idx + 1'b1;
          end else begin
            rd_vld <= 1'b0;
            if (!rd_vld) begin
              state <= ST_UPDATE;
            end
          end
        end
        ST_UPDATE: begin
          now_time <= comp_next;
          if (best_vld) begin
            ran      <= 1'b1;
            ran_slot <= best_idx;
            if (rem_next == '0) begin
              fin            <= 1'b1;
              comp           <= comp_next;
              done[best_idx] <= 1'b1;
            end
          end
          state <= (best_vld && (rem_next == '0)) ? ST_TAT : ST_EMIT;
        end
        ST_TAT: begin
          tat   <= alu_diff;
          state <= ST_WAIT;
        end
        ST_WAIT: begin
          wait_time <= alu_diff;
          state     <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            rsp.ran        <= ran;
            rsp.ran_slot   <= 4'(ran_slot);
            rsp.finished   <= fin;
            rsp.fin_time   <= comp;
            rsp.turnaround <= tat;
            rsp.waiting    <= wait_time;
            rsp.all_done   <= all_done;
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // served process had arrived by the current time
  a_best_arrived: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) && best_vld |-> best.arrival <= now_time)
    else $error("served process had not arrived");

  // time moves only in the update state
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    (state != ST_UPDATE) |=> now_time == $past(now_time))
    else $error("time moved outside update");

  // a finished process must have been served
  a_fin_ran: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.finished |-> rsp.ran)
    else $error("finished without service");

  // a tick beat starts a scan
  a_tick_scan: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req.cmd == psch_pkg::CMD_TICK) |=> state == ST_SCAN)
    else $error("tick did not start scan");

endmodule

>>> dv/tb_top.sv
// self-checking testbench for the preemptive priority scheduler
module tb_top;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_ready;
  psch_pkg::req_t             req       = '0;
  logic                       rsp_valid;
  logic                       rsp_ready = 1'b0;
  psch_pkg::rsp_t             rsp;
  logic                       cfg_we    = 1'b0;
  logic [psch_pkg::CFG_W-1:0] cfg_wdata = '0;

  preemptive_priority_scheduler u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog
  initial begin
    #40000000;
    $display("CHECK FAILED");
    $finish;
  end

  // scheduler state as the testbench sees it
  logic [psch_pkg::PRIO_W-1:0] sch_prio  [psch_pkg::SLOTS];
  logic [psch_pkg::TIME_W-1:0] sch_arr   [psch_pkg::SLOTS];
  logic [psch_pkg::TIME_W-1:0] sch_burst [psch_pkg::SLOTS];
  logic [psch_pkg::TIME_W-1:0] sch_rem   [psch_pkg::SLOTS];
  logic [psch_pkg::SLOTS-1:0]  sch_done  = '0;
  logic [psch_pkg::TIME_W-1:0] sch_now   = '0;
  logic [psch_pkg::CFG_W-1:0]  sch_count = '0;

  // stimulus bookkeeping at generation time
  psch_pkg::req_t             req_q[$];
  psch_pkg::rsp_t             sched_rsp_q[$];
  logic [psch_pkg::SLOTS-1:0] gen_loaded = '0;
  int unsigned                gen_time   = 0;
  int unsigned                gen_items  = 0;
  int                         fail_cnt   = 0;

  // sender and receiver pacing
  int burst_left  = 0;
  int gap_left    = 0;
  int got_cnt     = 0;
  int hold_left   = 0;
  int next_hold   = 400;
  int window_left = 0;
  int stall_level = 0;

  // scheduler result for one accepted beat, updating the local state
  function automatic psch_pkg::rsp_t sched_model(psch_pkg::req_t it);
    psch_pkg::rsp_t              r;
    int                          n;
    int                          best;
    logic [psch_pkg::TIME_W-1:0] comp;
    r = '0;
    n = (sch_count > psch_pkg::SLOTS) ? psch_pkg::SLOTS : int'(sch_count);
    if (it.cmd == psch_pkg::CMD_LOAD) begin
      sch_prio[it.slot]  = it.prio_value;
      sch_arr[it.slot]   = it.arrival;
      sch_burst[it.slot] = it.burst;
      sch_rem[it.slot]   = it.burst;
      sch_done[it.slot]  = 1'b0;
    end else begin
      best = -1;
      for (int i = 0; i < n; i++) begin
        if (!sch_done[i] && sch_arr[i] <= sch_now) begin
          if (best < 0 || sch_prio[i] < sch_prio[best]) best = i;
        end
      end
      if (best >= 0) begin
        r.ran      = 1'b1;
        r.ran_slot = best[3:0];
        if (sch_rem[best] != '0) sch_rem[best] = sch_rem[best] - 1'b1;
        if (sch_rem[best] == '0) begin
          comp = (sch_now < psch_pkg::TIME_MAX) ? sch_now + 1'b1 : psch_pkg::TIME_MAX;
          r.finished     = 1'b1;
          r.fin_time     = comp;
          r.turnaround   = (comp >= sch_arr[best]) ? comp - sch_arr[best] : '0;
          r.waiting      = (r.turnaround >= sch_burst[best]) ?
                           r.turnaround - sch_burst[best] : '0;
          sch_done[best] = 1'b1;
        end
      end
      if (sch_now < psch_pkg::TIME_MAX) sch_now = sch_now + 1'b1;
    end
    r.all_done = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!sch_done[i]) r.all_done = 1'b0;
    end
    return r;
  endfunction

  // driver: bursts of beats with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) sched_rsp_q.push_back(sched_model(req));
      if (!req_valid || req_ready) begin
        if (gap_left > 0) begin
          gap_left  = gap_left - 1;
          req_valid <= 1'b0;
        end else if (req_q.size() > 0) begin
          req       <= req_q.pop_front();
          req_valid <= 1'b1;
          if (burst_left > 0) burst_left = burst_left - 1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 10);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        got_cnt = got_cnt + 1;
        if (sched_rsp_q.size() == 0) begin
          fail_cnt = fail_cnt + 1;
          if (fail_cnt <= 10) $display("unexpected result beat: %p", rsp);
        end else begin
          psch_pkg::rsp_t want;
          want = sched_rsp_q.pop_front();
          if (rsp.ran !== want.ran || rsp.ran_slot !== want.ran_slot ||
              rsp.finished !== want.finished ||
              rsp.fin_time !== want.fin_time ||
              rsp.turnaround !== want.turnaround || rsp.waiting !== want.waiting ||
              rsp.all_done !== want.all_done) begin
            fail_cnt = fail_cnt + 1;
            if (fail_cnt <= 10) begin
              $display("mismatch at result %0d: exp %p got %p", got_cnt, want, rsp);
            end
          end
        end
      end
      // long hold-off while the sender keeps offering, else the stall pattern
      if (window_left == 0) begin
        stall_level = $urandom_range(0, 3);
        window_left = $urandom_range(16, 96);
      end else begin
        window_left = window_left - 1;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rsp_ready <= 1'b0;
      end else if (got_cnt >= next_hold && req_q.size() > 8) begin
        hold_left = 300;
        next_hold = next_hold + 900;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 3) >= stall_level);
      end
    end
  end

  // queue builders
  task automatic push_load(int unsigned s, int unsigned p, int unsigned a, int unsigned b);
    psch_pkg::req_t it;
    it.cmd        = psch_pkg::CMD_LOAD;
    it.slot       = s[3:0];
    it.prio_value = p[psch_pkg::PRIO_W-1:0];
    it.arrival    = a[psch_pkg::TIME_W-1:0];
    it.burst      = b[psch_pkg::TIME_W-1:0];
    req_q.push_back(it);
    gen_loaded[s[3:0]] = 1'b1;
    gen_items = gen_items + 1;
  endtask

  task automatic push_tick();
    psch_pkg::req_t it;
    it.cmd        = psch_pkg::CMD_TICK;
    it.slot       = 4'($urandom_range(0, 15));
    it.prio_value = psch_pkg::PRIO_W'($urandom_range(0, 255));
    it.arrival    = psch_pkg::TIME_W'($urandom_range(0, 65535));
    it.burst      = psch_pkg::TIME_W'($urandom_range(0, 65535));
    req_q.push_back(it);
    if (gen_time < psch_pkg::TIME_MAX) gen_time = gen_time + 1;
    gen_items = gen_items + 1;
  endtask

  function automatic int unsigned rand_prio();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, 7);
  endfunction

  function automatic int unsigned rand_arrival();
    int unsigned a;
    case ($urandom_range(0, 7))
      0: a = 0;
      1: a = $urandom_range(0, 65535);
      default: a = gen_time + $urandom_range(0, 6);
    endcase
    return (a > psch_pkg::TIME_MAX) ? psch_pkg::TIME_MAX : a;
  endfunction

  function automatic int unsigned rand_burst();
    if ($urandom_range(0, 15) == 0) return $urandom_range(1, 65535);
    return $urandom_range(1, 6);
  endfunction

  // wait until every queued beat has been sent and answered
  task automatic drain();
    do @(negedge clk);
    while (req_q.size() != 0 || req_valid || sched_rsp_q.size() != 0);
    repeat (30) @(posedge clk);
  endtask

  // register write, only once the block is idle
  task automatic set_count(int unsigned v);
    drain();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[psch_pkg::CFG_W-1:0];
    sch_count = v[psch_pkg::CFG_W-1:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // stimulus
  initial begin
    int unsigned cnt;
    int          n;
    int unsigned b;
    int unsigned work;
    int unsigned ticks;
    int unsigned rand_start;
    int          phase_no;
    bit          reload;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no slots in use: idle tick, all done
    set_count(0);
    push_tick();
    push_load(15, 255, 65535, 65535);
    push_tick();

    // process not yet arrived, then idle tick
    set_count(2);
    push_load(0, 255, 0, 1);
    push_load(1, 0, 65535, 65535);
    push_tick();
    push_tick();

    // tie on priority, zero burst finishing at once
    push_load(1, 255, 0, 2);
    push_load(0, 255, 0, 0);
    push_tick();
    push_tick();
    push_tick();
    push_tick();

    // late arrival with better priority preempts
    push_load(0, 5, gen_time, 3);
    push_load(1, 1, gen_time + 1, 1);
    repeat (4) push_tick();

    // random phases
    rand_start = gen_items;
    phase_no = 0;
    while (gen_items - rand_start < 1850) begin
      case (phase_no)
        0: cnt = 16;
        1: cnt = 31;
        default: begin
          case ($urandom_range(0, 15))
            0: cnt = 0;
            1, 2: cnt = $urandom_range(17, 31);
            3, 4, 5, 6: cnt = $urandom_range(6, 16);
            default: cnt = $urandom_range(1, 5);
          endcase
        end
      endcase
      set_count(cnt);
      n = (cnt > psch_pkg::SLOTS) ? psch_pkg::SLOTS : cnt;
      reload = ($urandom_range(0, 3) != 0);
      work = 0;
      for (int i = 0; i < n; i++) begin
        if (reload || !gen_loaded[i]) begin
          b = rand_burst();
          push_load(i, rand_prio(), rand_arrival(), b);
          work = work + ((b > 12) ? 12 : b);
        end
      end
      ticks = work + $urandom_range(1, 6);
      for (int j = 0; j < ticks; j++) begin
        if ($urandom_range(0, 9) == 0) begin
          push_load($urandom_range(0, 15), rand_prio(), rand_arrival(), rand_burst());
        end
        push_tick();
      end
      phase_no = phase_no + 1;
    end

    // one process that never arrives beside one that runs, then a fresh set
    set_count(2);
    push_load(0, 3, 0, 2);
    push_load(1, 0, 65535, 1);
    repeat (4) push_tick();
    set_count(3);
    for (int i = 0; i < 3; i++) push_load(i, rand_prio(), rand_arrival(), $urandom_range(1, 4));
    repeat (14) push_tick();

    drain();
    repeat (40) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
